FILE: rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Pixel types, hue sector codes and fixed-point constants shared by the
// converter modules.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef logic [2:0] sector_type;

   // Hue sectors of 60 degrees each, named after the color at their start.
   localparam sector_type SEC_RED     = 3'd0;
   localparam sector_type SEC_YELLOW  = 3'd1;
   localparam sector_type SEC_GREEN   = 3'd2;
   localparam sector_type SEC_CYAN    = 3'd3;
   localparam sector_type SEC_BLUE    = 3'd4;
   localparam sector_type SEC_MAGENTA = 3'd5;

   localparam logic [8:0] DEG_FULL   = 9'd360;
   localparam logic [5:0] DEG_SECTOR = 6'd60;

   // Rounding offsets: half of the divisor.
   localparam logic [6:0]  HALF_BYTE   = 7'd127;
   localparam logic [4:0]  HALF_SECTOR = 5'd30;

   // floor(n / 60) = (n * DIV60_MUL) >> DIV60_SHIFT for every n below 23831.
   localparam logic [14:0] DIV60_MUL   = 15'd17477;
   localparam int          DIV60_SHIFT = 20;

   // First degree of each sector.
   localparam logic [8:0] SECTOR_BASE [6] = '{9'd0, 9'd60, 9'd120, 9'd180, 9'd240, 9'd300};

endpackage

FILE: rtl/hsvrgb_hue_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue sector split
// Splits a hue below 360 degrees into its 60 degree sector and the ramp
// fraction of the secondary component within that sector.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split
   import hsvrgb_pkg::*;
(
   input  logic [8:0]  hue,
   output sector_type  sector,
   output logic [5:0]  frac
);

   logic [8:0] base;
   logic [8:0] rem_wide;
   logic [5:0] rem;

   always_comb begin
      if (hue >= SECTOR_BASE[5]) begin
         sector = SEC_MAGENTA;
      end else if (hue >= SECTOR_BASE[4]) begin
         sector = SEC_BLUE;
      end else if (hue >= SECTOR_BASE[3]) begin
         sector = SEC_CYAN;
      end else if (hue >= SECTOR_BASE[2]) begin
         sector = SEC_GREEN;
      end else if (hue >= SECTOR_BASE[1]) begin
         sector = SEC_YELLOW;
      end else begin
         sector = SEC_RED;
      end
   end

   assign base     = SECTOR_BASE[sector];
   assign rem_wide = hue - base;
   assign rem      = rem_wide[5:0];

   // The secondary component rises in even sectors and falls in odd ones.
   assign frac = sector[0] ? (DEG_SECTOR - rem) : rem;

endmodule

FILE: rtl/hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one hue/saturation/value pixel into an
// 8-bit red, green and blue pixel every clock.
// ----------------------------------------------------------------------------
// Usage:
// A pixel beat is taken on req_pixel at each rising edge where start is high
// and busy is low. The pipeline never backs up, so busy stays low and a new
// pixel may enter on every clock: throughput is one pixel per cycle.
// The result appears on rsp_pixel with rsp_valid high for exactly one cycle,
// once the pixel has passed through every stage. The stages are: hue wrap and the
// value times saturation product; chroma by a rounded divide by 255 and the
// hue sector split; chroma times ramp fraction and the offset; a rounded
// divide by 60 through a reciprocal multiply; sector channel select plus
// offset into the output register.
// The receiver cannot stall; every result is taken in its one cycle.
// A synchronous reset clears all stage valid bits, so pixels in flight are
// dropped and no result follows until new pixels are started.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
   import hsvrgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  hsv_type req_pixel,
   output logic    rsp_valid,
   output rgb_type rsp_pixel
);

   logic accept;

   // Stage 1
   logic        s1_valid_ff, s1_valid_in;
   logic [8:0]  s1_hue_ff, s1_hue_in;
   logic [15:0] s1_prod_ff, s1_prod_in;
   logic [7:0]  s1_val_ff, s1_val_in;

   // Stage 2
   logic        s2_valid_ff, s2_valid_in;
   logic [7:0]  s2_chroma_ff, s2_chroma_in;
   sector_type  s2_sector_ff, s2_sector_in;
   logic [5:0]  s2_frac_ff, s2_frac_in;
   logic [7:0]  s2_val_ff, s2_val_in;
   logic [16:0] s2_biased;
   logic [16:0] s2_quot;

   // Stage 3
   logic        s3_valid_ff, s3_valid_in;
   logic [13:0] s3_prod_ff, s3_prod_in;
   logic [7:0]  s3_chroma_ff, s3_chroma_in;
   logic [7:0]  s3_offset_ff, s3_offset_in;
   sector_type  s3_sector_ff, s3_sector_in;

   // Stage 4
   logic        s4_valid_ff, s4_valid_in;
   logic [7:0]  s4_x_ff, s4_x_in;
   logic [7:0]  s4_chroma_ff, s4_chroma_in;
   logic [7:0]  s4_offset_ff, s4_offset_in;
   sector_type  s4_sector_ff, s4_sector_in;
   logic [13:0] s4_biased;
   logic [28:0] s4_scaled;

   // Stage 5 (output)
   logic        s5_valid_ff, s5_valid_in;
   rgb_type     s5_pixel_ff, s5_pixel_in;
   logic [7:0]  s5_r, s5_g, s5_b;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: wrap the hue into 0..359 and form value times saturation.
   assign s1_valid_in = accept;
   assign s1_hue_in   = (req_pixel.hue >= DEG_FULL) ? (req_pixel.hue - DEG_FULL)
                                                    : req_pixel.hue;
   assign s1_prod_in  = req_pixel.brightness * req_pixel.saturation;
   assign s1_val_in   = req_pixel.brightness;

   // Stage 2: chroma = round(prod / 255) with the identity
   // floor(t / 255) = (t + (t >> 8) + 1) >> 8, exact for t below 65535.
   assign s2_biased    = {1'b0, s1_prod_ff} + {10'd0, HALF_BYTE};
   assign s2_quot      = (s2_biased + (s2_biased >> 8) + 17'd1) >> 8;
   assign s2_chroma_in = s2_quot[7:0];
   assign s2_valid_in  = s1_valid_ff;
   assign s2_val_in    = s1_val_ff;

   hsvrgb_hue_split u_hue_split (
      .hue    (s1_hue_ff),
      .sector (s2_sector_in),
      .frac   (s2_frac_in)
   );

   // Stage 3: chroma times ramp fraction, and the offset added to all channels.
   assign s3_valid_in  = s2_valid_ff;
   assign s3_prod_in   = s2_chroma_ff * s2_frac_ff;
   assign s3_chroma_in = s2_chroma_ff;
   assign s3_offset_in = s2_val_ff - s2_chroma_ff;
   assign s3_sector_in = s2_sector_ff;

   // Stage 4: secondary component = round(prod / 60) via a reciprocal multiply.
   assign s4_biased    = s3_prod_ff + {9'd0, HALF_SECTOR};
   assign s4_scaled    = s4_biased * DIV60_MUL;
   assign s4_x_in      = s4_scaled[DIV60_SHIFT +: 8];
   assign s4_valid_in  = s3_valid_ff;
   assign s4_chroma_in = s3_chroma_ff;
   assign s4_offset_in = s3_offset_ff;
   assign s4_sector_in = s3_sector_ff;

   // Stage 5: place chroma and the secondary component by sector, then add the offset.
   always_comb begin
      case (s4_sector_ff)
         SEC_RED: begin
            s5_r = s4_chroma_ff; s5_g = s4_x_ff;      s5_b = 8'd0;
         end
         SEC_YELLOW: begin
            s5_r = s4_x_ff;      s5_g = s4_chroma_ff; s5_b = 8'd0;
         end
         SEC_GREEN: begin
            s5_r = 8'd0;         s5_g = s4_chroma_ff; s5_b = s4_x_ff;
         end
         SEC_CYAN: begin
            s5_r = 8'd0;         s5_g = s4_x_ff;      s5_b = s4_chroma_ff;
         end
         SEC_BLUE: begin
            s5_r = s4_x_ff;      s5_g = 8'd0;         s5_b = s4_chroma_ff;
         end
         default: begin
            s5_r = s4_chroma_ff; s5_g = 8'd0;         s5_b = s4_x_ff;
         end
      endcase
   end

   assign s5_valid_in       = s4_valid_ff;
   assign s5_pixel_in.red   = s5_r + s4_offset_ff;
   assign s5_pixel_in.green = s5_g + s4_offset_ff;
   assign s5_pixel_in.blue  = s5_b + s4_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_ff    <= s1_hue_in;
      s1_prod_ff   <= s1_prod_in;
      s1_val_ff    <= s1_val_in;
      s2_chroma_ff <= s2_chroma_in;
      s2_sector_ff <= s2_sector_in;
      s2_frac_ff   <= s2_frac_in;
      s2_val_ff    <= s2_val_in;
      s3_prod_ff   <= s3_prod_in;
      s3_chroma_ff <= s3_chroma_in;
      s3_offset_ff <= s3_offset_in;
      s3_sector_ff <= s3_sector_in;
      s4_x_ff      <= s4_x_in;
      s4_chroma_ff <= s4_chroma_in;
      s4_offset_ff <= s4_offset_in;
      s4_sector_ff <= s4_sector_in;
      s5_pixel_ff  <= s5_pixel_in;
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_pixel = s5_pixel_ff;

   // Every started beat comes out as a result beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted beat did not produce a result after five cycles");

   // The strongest channel always equals the brightness of the input beat.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel.red == $past(req_pixel.brightness, 5)
                  || rsp_pixel.green == $past(req_pixel.brightness, 5)
                  || rsp_pixel.blue == $past(req_pixel.brightness, 5)))
      else $error("no channel matches the input brightness");

   // Zero saturation gives a gray pixel.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_pixel.saturation, 5) == 8'd0)
      |-> (rsp_pixel.red == rsp_pixel.green && rsp_pixel.green == rsp_pixel.blue))
      else $error("unsaturated beat gave a non-gray result");

endmodule

FILE: sim/hsv_to_rgb_converter_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches the pixel request and result channels of the converter, works out
// the red, green and blue that each accepted pixel must give, and compares
// every result beat, channel by channel, with the oldest outstanding pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_checker
   import hsvrgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  hsv_type req_pixel,
   input  logic    rsp_valid,
   input  rgb_type rsp_pixel,
   output int      mismatch_count,
   output int      pending_count,
   output int      checked_count
);

   localparam int unsigned BYTE_FULL = 255;

   typedef struct packed {
      hsv_type pixel;
      rgb_type color;
   } conversion_type;

   conversion_type wanted_colors[$];
   int mismatches = 0;
   int checked    = 0;

   // Rounded fixed-point conversion; the chroma and secondary divides round half up.
   function automatic rgb_type convert_hsv(hsv_type px);
      int unsigned deg, chroma, ramp, secondary, offset;
      int unsigned red, green, blue;
      sector_type  sector;
      rgb_type     color;
      deg       = int'(px.hue) % int'(DEG_FULL);
      chroma    = (int'(px.brightness) * int'(px.saturation) + BYTE_FULL / 2) / BYTE_FULL;
      sector    = sector_type'(deg / int'(DEG_SECTOR));
      ramp      = deg % int'(DEG_SECTOR);
      // Odd sectors ramp down instead of up.
      if (sector[0]) begin
         ramp = int'(DEG_SECTOR) - ramp;
      end
      secondary = (chroma * ramp + int'(DEG_SECTOR) / 2) / int'(DEG_SECTOR);
      offset    = int'(px.brightness) - chroma;
      case (sector)
         SEC_RED: begin
            red = chroma;    green = secondary; blue = 0;
         end
         SEC_YELLOW: begin
            red = secondary; green = chroma;    blue = 0;
         end
         SEC_GREEN: begin
            red = 0;         green = chroma;    blue = secondary;
         end
         SEC_CYAN: begin
            red = 0;         green = secondary; blue = chroma;
         end
         SEC_BLUE: begin
            red = secondary; green = 0;         blue = chroma;
         end
         default: begin
            red = chroma;    green = 0;         blue = secondary;
         end
      endcase
      color.red   = 8'(red + offset);
      color.green = 8'(green + offset);
      color.blue  = 8'(blue + offset);
      return color;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_channel(input string name, input logic [7:0] got,
                                input logic [7:0] wanted, input hsv_type px);
      if (got !== wanted) begin
         report_mismatch($sformatf("%s is %0d, should be %0d (hue %0d sat %0d val %0d)",
                                   name, got, wanted, px.hue, px.saturation,
                                   px.brightness));
      end
   endtask

   always @(posedge clock) begin : watch
      conversion_type entry;
      if (!reset) begin
         if (start && !busy) begin
            entry.pixel = req_pixel;
            entry.color = convert_hsv(req_pixel);
            wanted_colors = {wanted_colors, entry};
         end
         if (rsp_valid) begin
            if (wanted_colors.size() == 0) begin
               report_mismatch($sformatf("result beat %h with no pixel outstanding",
                                         rsp_pixel));
            end else begin
               entry = wanted_colors.pop_front();
               checked++;
               check_channel("red", rsp_pixel.red, entry.color.red, entry.pixel);
               check_channel("green", rsp_pixel.green, entry.color.green, entry.pixel);
               check_channel("blue", rsp_pixel.blue, entry.color.blue, entry.pixel);
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= wanted_colors.size();
      checked_count  <= checked;
   end

endmodule

FILE: sim/hsv_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then random pixels, with random gaps
// between beats and stretches of back-to-back beats, into the converter.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_tb
   import hsvrgb_pkg::*;
();

   localparam int RANDOM_PIXELS = 1900;
   localparam int LATENCY       = 5;
   localparam int CYCLE_LIMIT   = 200000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   hsv_type req_pixel = '0;
   logic    busy;
   logic    rsp_valid;
   rgb_type rsp_pixel;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int cycle_count    = 0;
   int directed_sent  = 0;
   int random_sent    = 0;
   bit back_to_back   = 1'b0;

   int corner_hues [18] = '{0, 1, 30, 59, 60, 90, 119, 120, 179, 180, 239, 240,
                            299, 300, 359, 360, 361, 511};

   hsv_to_rgb_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_pixel)
   );

   hsv_to_rgb_converter_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_pixel      (rsp_pixel),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d pixels outstanding.",
                  cycle_count, pending_count);
         $display("FAIL hsv_to_rgb_converter_unit");
         $finish;
      end
   end

   function automatic hsv_type make_pixel(input int hue, input int sat, input int val);
      hsv_type px;
      px.hue        = 9'(hue);
      px.saturation = 8'(sat);
      px.brightness = 8'(val);
      return px;
   endfunction

   function automatic int random_byte();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic hsv_type random_pixel();
      int hue;
      // Some hues land on or just below a sector edge.
      if ($urandom_range(0, 7) == 0) begin
         hue = 60 * $urandom_range(1, 8) - $urandom_range(0, 1);
      end else begin
         hue = $urandom_range(0, 511);
      end
      return make_pixel(hue, random_byte(), random_byte());
   endfunction

   // Holds start low for a random gap, then keeps it high until the beat is taken.
   task automatic send_pixel(input hsv_type px);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_hues[i]) begin
         send_pixel(make_pixel(corner_hues[i], 255, 255));
         directed_sent++;
      end
      // Grey, black, all zero, and near-extreme fractions.
      send_pixel(make_pixel(45, 0, 255));
      send_pixel(make_pixel(45, 255, 0));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(200, 1, 254));
      send_pixel(make_pixel(330, 128, 127));
      directed_sent += 5;

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 64 == 0) begin
            back_to_back = ($urandom_range(0, 2) == 0);
         end
         send_pixel(random_pixel());
         random_sent++;
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);

      $display("Sent %0d pixels (%0d corner, %0d random) over all hue sectors and wrapped hues.",
               directed_sent + random_sent, directed_sent, random_sent);
      $display("Compared %0d result beats channel by channel: %0d mismatches, %0d unanswered.",
               checked_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS hsv_to_rgb_converter_unit");
      end else begin
         $display("FAIL hsv_to_rgb_converter_unit");
      end
      $finish;
   end

endmodule
